// ===== rtl/command_line_argument_splitter_defines.svh =====
// Assertion helpers used by the file that checks its own logic.
`ifndef COMMAND_LINE_ARGUMENT_SPLITTER_DEFINES_SVH
`define COMMAND_LINE_ARGUMENT_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CLAS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CLAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/clas_pkg.sv =====
package clas_pkg;

    localparam int RUN_BITS       = 16;
    localparam int ARG_COUNT_BITS = 16;
    localparam int MAX_RES        = 4;

    localparam logic [RUN_BITS-1:0]       RUN_MAX = {RUN_BITS{1'b1}};
    localparam logic [ARG_COUNT_BITS-1:0] ARG_MAX = {ARG_COUNT_BITS{1'b1}};

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        M_FIRST_START  = 3'd0,
        M_FIRST_PLAIN  = 3'd1,
        M_FIRST_QUOTED = 3'd2,
        M_GAP          = 3'd3,
        M_PLAIN        = 3'd4,
        M_QUOTED       = 3'd5,
        M_QUOTE_SEEN   = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        K_CHAR = 2'd0,
        K_END  = 2'd1,
        K_EOL  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_char;
        logic [15:0] repeat_res;
        logic [15:0] arg_total;
        logic        last;
    } t_res;

    typedef struct packed {
        t_mode                     mode;
        logic [RUN_BITS-1:0]       pend;
        logic [ARG_COUNT_BITS-1:0] argc;
    } t_state;

    function automatic logic [15:0] sat_run(input logic [RUN_BITS-1:0] v);
        logic [RUN_BITS+15:0] w;
        w = {16'b0, v};
        if (w > (RUN_BITS + 16)'(17'h0FFFF)) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

    function automatic logic [15:0] sat_arg(input logic [ARG_COUNT_BITS-1:0] v);
        logic [ARG_COUNT_BITS+15:0] w;
        w = {16'b0, v};
        if (w > (ARG_COUNT_BITS + 16)'(17'h0FFFF)) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

    function automatic t_res mk_char(input logic [7:0] c, input logic [15:0] rep);
        t_res r;
        r.kind       = K_CHAR;
        r.out_char   = c;
        r.repeat_res = rep;
        r.arg_total  = 16'd0;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic t_res mk_end();
        t_res r;
        r = '0;
        r.kind = K_END;
        return r;
    endfunction

    function automatic t_res mk_eol(input logic [15:0] total);
        t_res r;
        r = '0;
        r.kind      = K_EOL;
        r.arg_total = total;
        r.last      = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/clas_if.sv =====
interface clas_in_if import clas_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_line;

    modport source (output valid, output ch, output end_of_line, input ready);
    modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface clas_out_if import clas_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_char;
    logic [15:0] repeat_res;
    logic [15:0] arg_total;
    logic        last;

    modport source (output valid, output kind, output out_char, output repeat_res,
                    output arg_total, output last, input ready);
    modport sink   (input valid, input kind, input out_char, input repeat_res,
                    input arg_total, input last, output ready);
endinterface

// ===== rtl/clas_step.sv =====
module clas_step import clas_pkg::*; (
    input  logic [7:0] i_ch,
    input  logic       i_eol,
    input  t_state     i_st,
    output t_state     o_st,
    output t_res       o_res [MAX_RES],
    output logic [2:0] o_cnt
);

    always_comb begin
        t_mode                     m;
        logic [RUN_BITS-1:0]       p;
        logic [ARG_COUNT_BITS-1:0] a;
        logic [RUN_BITS-1:0]       half;
        logic [2:0]                n;
        logic                      feed;
        logic                      done;
        logic                      is_q;
        logic                      is_bs;
        logic                      is_ws;

        m     = i_st.mode;
        p     = i_st.pend;
        a     = i_st.argc;
        n     = 3'd0;
        feed  = 1'b0;
        done  = 1'b0;
        half  = '0;
        is_q  = (i_ch == CH_QUOTE);
        is_bs = (i_ch == CH_BSLASH);
        is_ws = (i_ch == CH_SPACE) || (i_ch == CH_TAB);
        for (int k = 0; k < MAX_RES; k++) begin
            o_res[k] = '0;
        end

        case (i_st.mode)
            M_FIRST_START: begin
                a = ARG_COUNT_BITS'(1);
                if (is_q) begin
                    m = M_FIRST_QUOTED;
                end else if (is_ws) begin
                    o_res[n[1:0]] = mk_end();
                    n = n + 3'd1;
                    m = M_GAP;
                end else begin
                    o_res[n[1:0]] = mk_char(i_ch, 16'd1);
                    n = n + 3'd1;
                    m = M_FIRST_PLAIN;
                end
            end
            M_FIRST_PLAIN: begin
                if (is_ws) begin
                    o_res[n[1:0]] = mk_end();
                    n = n + 3'd1;
                    m = M_GAP;
                end else begin
                    o_res[n[1:0]] = mk_char(i_ch, 16'd1);
                    n = n + 3'd1;
                end
            end
            M_FIRST_QUOTED: begin
                if (is_q) begin
                    o_res[n[1:0]] = mk_end();
                    n = n + 3'd1;
                    m = M_GAP;
                end else begin
                    o_res[n[1:0]] = mk_char(i_ch, 16'd1);
                    n = n + 3'd1;
                end
            end
            M_GAP: begin
                if (!is_ws) begin
                    if (a != ARG_MAX) begin
                        a = a + ARG_COUNT_BITS'(1);
                    end
                    // A quote that opens an argument on the last byte is a literal quote.
                    if (is_q && i_eol) begin
                        o_res[n[1:0]] = mk_char(CH_QUOTE, 16'd1);
                        n = n + 3'd1;
                        o_res[n[1:0]] = mk_end();
                        n = n + 3'd1;
                    end else begin
                        m    = M_PLAIN;
                        p    = '0;
                        feed = 1'b1;
                    end
                end
            end
            default: begin
                feed = 1'b1;
            end
        endcase

        if (feed) begin
            if (m == M_QUOTE_SEEN) begin
                if (is_q) begin
                    o_res[n[1:0]] = mk_char(CH_QUOTE, 16'd1);
                    n = n + 3'd1;
                    m = M_QUOTED;
                    done = 1'b1;
                end else begin
                    m = M_PLAIN;
                end
            end
            if (!done && p != '0) begin
                if (is_bs) begin
                    if (p != RUN_MAX) begin
                        p = p + RUN_BITS'(1);
                    end
                    done = 1'b1;
                end else if (is_q) begin
                    // Each pair of backslashes gives one; an odd one escapes the quote.
                    half = p >> 1;
                    if (half != '0) begin
                        o_res[n[1:0]] = mk_char(CH_BSLASH, sat_run(half));
                        n = n + 3'd1;
                    end
                    if (p[0]) begin
                        o_res[n[1:0]] = mk_char(CH_QUOTE, 16'd1);
                        n = n + 3'd1;
                        done = 1'b1;
                    end
                    p = '0;
                end else begin
                    o_res[n[1:0]] = mk_char(CH_BSLASH, sat_run(p));
                    n = n + 3'd1;
                    p = '0;
                end
            end
            if (!done) begin
                if (is_bs) begin
                    p = RUN_BITS'(1);
                end else if (m == M_QUOTED) begin
                    if (is_q) begin
                        m = M_QUOTE_SEEN;
                    end else begin
                        o_res[n[1:0]] = mk_char(i_ch, 16'd1);
                        n = n + 3'd1;
                    end
                end else if (is_q) begin
                    m = M_QUOTED;
                end else if (is_ws) begin
                    o_res[n[1:0]] = mk_end();
                    n = n + 3'd1;
                    m = M_GAP;
                end else begin
                    o_res[n[1:0]] = mk_char(i_ch, 16'd1);
                    n = n + 3'd1;
                end
            end
        end

        if (i_eol) begin
            if (p != '0) begin
                o_res[n[1:0]] = mk_char(CH_BSLASH, sat_run(p));
                n = n + 3'd1;
            end
            if (m != M_GAP && m != M_FIRST_START) begin
                o_res[n[1:0]] = mk_end();
                n = n + 3'd1;
            end
            o_res[n[1:0]] = mk_eol(sat_arg(a));
            n = n + 3'd1;
            m = M_FIRST_START;
            p = '0;
            a = '0;
        end

        o_st.mode = m;
        o_st.pend = p;
        o_st.argc = a;
        o_cnt     = n;
    end

endmodule

// ===== rtl/clas_outq.sv =====
module clas_outq import clas_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_res       i_res [MAX_RES],
    input  logic [2:0] i_cnt,
    input  logic       i_pop,
    output t_res       o_head,
    output logic [2:0] o_cnt
);

    t_res       r_res [MAX_RES];
    logic [2:0] r_cnt;

    // A load only happens once the queue is empty or its last beat leaves now.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (i_pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end else if (i_pop) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_res[k] <= r_res[k+1];
            end
        end
    end

    assign o_head = r_res[0];
    assign o_cnt  = r_cnt;

endmodule

// ===== rtl/command_line_argument_splitter.sv =====
// The first result beat of a character is valid in the cycle after it is accepted.
// Throughput: one character per cycle while it yields at most one result beat and the
// output is ready; the beats of a character (up to four) wait in a four-entry result queue,
// and the next character enters in the cycle that the last queued beat leaves,
// or at once when the queue is empty.
// Reset (synchronous, active low) returns the parser to the first-argument start.
`include "command_line_argument_splitter_defines.svh"

module command_line_argument_splitter import clas_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clas_in_if.sink    i_in,
    clas_out_if.source o_out
);

    t_state     r_st;
    t_state     n_st;
    t_res       step_res [MAX_RES];
    logic [2:0] step_cnt;
    t_res       head;
    logic [2:0] q_cnt;
    logic       accept;
    logic       pop;

    assign pop        = o_out.valid && o_out.ready;
    assign i_in.ready = (q_cnt == 3'd0) || ((q_cnt == 3'd1) && o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    clas_step u_step (
        .i_ch  (i_in.ch),
        .i_eol (i_in.end_of_line),
        .i_st  (r_st),
        .o_st  (n_st),
        .o_res (step_res),
        .o_cnt (step_cnt)
    );

    clas_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_res   (step_res),
        .i_cnt   (step_cnt),
        .i_pop   (pop),
        .o_head  (head),
        .o_cnt   (q_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode <= M_FIRST_START;
            r_st.pend <= '0;
            r_st.argc <= '0;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

    assign o_out.valid      = (q_cnt != 3'd0);
    assign o_out.kind       = head.kind;
    assign o_out.out_char   = head.out_char;
    assign o_out.repeat_res = head.repeat_res;
    assign o_out.arg_total  = head.arg_total;
    assign o_out.last       = head.last;

    // The queue never holds more than one beat when a new character may enter.
    `CLAS_ASSERT_NOW(a_ready_room, q_cnt > 3'd1, !i_in.ready)
    // The end-of-line beat is always an end-of-line item.
    `CLAS_ASSERT_NOW(a_last_kind, o_out.valid && o_out.last, o_out.kind == K_EOL)
    // After the final character the parser is back at the first-argument start.
    `CLAS_ASSERT_NEXT(a_eol_reset, accept && i_in.end_of_line, r_st.mode == M_FIRST_START && r_st.argc == '0)
    // A drained beat without a new character shortens the queue by one.
    `CLAS_ASSERT_NEXT(a_pop_count, pop && !accept, q_cnt == $past(q_cnt) - 3'd1)

endmodule

// ===== test/command_line_argument_splitter_tb.sv =====
`timescale 1ns / 1ps

module command_line_argument_splitter_tb;
    import clas_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       eol;
    } char_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    clas_in_if  in_bus ();
    clas_out_if out_bus ();

    command_line_argument_splitter u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #1 clk = ~clk;

    char_beat_t  line_q [$];
    t_res        split_q [$];
    int unsigned queued_chars = 0;
    int unsigned errs = 0;
    bit          pace = 1'b1;
    int unsigned hold = 0;
    int unsigned stall = 0;
    char_beat_t  next_beat;

    // Parser state as the splitter should hold it.
    t_mode                     pmode = M_FIRST_START;
    logic [RUN_BITS-1:0]       pend = '0;
    logic [ARG_COUNT_BITS-1:0] argc = '0;

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic void note_run(logic [7:0] c, logic [RUN_BITS-1:0] rep);
        t_res r;
        r.kind       = K_CHAR;
        r.out_char   = c;
        r.repeat_res = 16'(rep);
        r.arg_total  = 16'd0;
        r.last       = 1'b0;
        split_q.push_back(r);
    endfunction

    function automatic void note_end();
        t_res r;
        r      = '0;
        r.kind = K_END;
        split_q.push_back(r);
    endfunction

    // One character inside any argument after the first.
    function automatic void arg_char(logic [7:0] c);
        logic [RUN_BITS-1:0] half;
        bit                  odd;
        if (pmode == M_QUOTE_SEEN) begin
            if (c == CH_QUOTE) begin
                note_run(CH_QUOTE, 1);
                pmode = M_QUOTED;
                return;
            end
            pmode = M_PLAIN;
        end
        if (pend != 0) begin
            if (c == CH_BSLASH) begin
                if (pend != RUN_MAX) pend++;
                return;
            end
            if (c == CH_QUOTE) begin
                half = pend >> 1;
                odd  = pend[0];
                pend = '0;
                if (half != 0) note_run(CH_BSLASH, half);
                if (odd) begin
                    note_run(CH_QUOTE, 1);
                    return;
                end
            end else begin
                note_run(CH_BSLASH, pend);
                pend = '0;
            end
        end
        if (c == CH_BSLASH) begin
            pend = 1;
        end else if (pmode == M_QUOTED) begin
            if (c == CH_QUOTE) pmode = M_QUOTE_SEEN;
            else note_run(c, 1);
        end else if (c == CH_QUOTE) begin
            pmode = M_QUOTED;
        end else if (is_blank(c)) begin
            note_end();
            pmode = M_GAP;
        end else begin
            note_run(c, 1);
        end
    endfunction

    function automatic void split_char(logic [7:0] c, logic eol);
        t_res r;
        case (pmode)
            M_FIRST_START: begin
                argc = 1;
                if (c == CH_QUOTE) begin
                    pmode = M_FIRST_QUOTED;
                end else if (is_blank(c)) begin
                    note_end();
                    pmode = M_GAP;
                end else begin
                    note_run(c, 1);
                    pmode = M_FIRST_PLAIN;
                end
            end
            M_FIRST_PLAIN: begin
                if (is_blank(c)) begin
                    note_end();
                    pmode = M_GAP;
                end else begin
                    note_run(c, 1);
                end
            end
            M_FIRST_QUOTED: begin
                if (c == CH_QUOTE) begin
                    note_end();
                    pmode = M_GAP;
                end else begin
                    note_run(c, 1);
                end
            end
            M_GAP: begin
                if (!is_blank(c)) begin
                    if (argc != ARG_MAX) argc++;
                    // A quote that opens an argument on the last byte stands for itself.
                    if (c == CH_QUOTE && eol) begin
                        note_run(CH_QUOTE, 1);
                        note_end();
                    end else begin
                        pmode = M_PLAIN;
                        pend  = '0;
                        arg_char(c);
                    end
                end
            end
            default: arg_char(c);
        endcase
        if (eol) begin
            if (pend != 0) note_run(CH_BSLASH, pend);
            if (pmode != M_GAP && pmode != M_FIRST_START) note_end();
            r           = '0;
            r.kind      = K_EOL;
            r.arg_total = 16'(argc);
            r.last      = 1'b1;
            split_q.push_back(r);
            pmode = M_FIRST_START;
            pend  = '0;
            argc  = '0;
        end
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned r;
        if (!pace) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errs++;
            if (errs <= 100) $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // Driver: presents queued characters, with random gaps between beats.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_bus.valid       <= 1'b0;
            in_bus.ch          <= 8'h00;
            in_bus.end_of_line <= 1'b0;
            hold               <= 0;
        end else begin
            if (in_bus.valid && in_bus.ready) split_char(in_bus.ch, in_bus.end_of_line);
            if (!in_bus.valid || in_bus.ready) begin
                if (hold != 0) begin
                    in_bus.valid <= 1'b0;
                    hold         <= hold - 1;
                end else if (line_q.size() != 0) begin
                    next_beat          = line_q.pop_front();
                    in_bus.valid       <= 1'b1;
                    in_bus.ch          <= next_beat.ch;
                    in_bus.end_of_line <= next_beat.eol;
                    hold               <= draw_gap();
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes result beats with random stalls and checks each one.
    always @(posedge clk) begin
        t_res want;
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
            stall         <= 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (split_q.size() == 0) begin
                    errs++;
                    if (errs <= 100) $error("result beat with none expected, kind %0d",
                                            out_bus.kind);
                end else begin
                    want = split_q.pop_front();
                    check_field("kind", 16'(want.kind), 16'(out_bus.kind));
                    check_field("out_char", 16'(want.out_char), 16'(out_bus.out_char));
                    check_field("repeat_res", want.repeat_res, out_bus.repeat_res);
                    check_field("arg_total", want.arg_total, out_bus.arg_total);
                    check_field("last", 16'(want.last), 16'(out_bus.last));
                end
            end
            if (stall != 0) begin
                out_bus.ready <= 1'b0;
                stall         <= stall - 1;
            end else begin
                out_bus.ready <= 1'b1;
                stall         <= draw_gap();
            end
        end
    end

    function automatic void queue_char(logic [7:0] c, logic eol);
        char_beat_t b;
        b.ch  = c;
        b.eol = eol;
        line_q.push_back(b);
        queued_chars++;
    endfunction

    function automatic void queue_text(string s, bit close);
        for (int i = 0; i < s.len(); i++) queue_char(s[i], close && i == s.len() - 1);
    endfunction

    // Mostly structured text: blanks, quotes and backslash runs among other bytes.
    function automatic void queue_random_line(int unsigned len, bit noise);
        logic [7:0]  text [$];
        int unsigned r;
        int unsigned run;
        while (text.size() < len) begin
            r = $urandom_range(0, 99);
            if (noise || r >= 50) begin
                text.push_back(8'($urandom_range(1, 255)));
            end else if (r < 12) begin
                text.push_back(CH_SPACE);
            end else if (r < 16) begin
                text.push_back(CH_TAB);
            end else if (r < 32) begin
                text.push_back(CH_QUOTE);
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
                repeat (run) text.push_back(CH_BSLASH);
            end
        end
        foreach (text[i]) queue_char(text[i], i == text.size() - 1);
    endfunction

    // Sampled on the falling edge, where every handshake signal has settled.
    task automatic drain();
        while (line_q.size() != 0 || in_bus.valid || split_q.size() != 0) @(negedge clk);
    endtask

    initial begin
        int unsigned target;
        int unsigned len;
        in_bus.valid       = 1'b0;
        in_bus.ch          = 8'h00;
        in_bus.end_of_line = 1'b0;
        out_bus.ready      = 1'b0;
        rst_n              = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Extreme byte values, a single-byte line.
        queue_char(8'hFF, 1'b0);
        queue_char(CH_SPACE, 1'b0);
        queue_char(8'h01, 1'b1);
        queue_char(8'h01, 1'b1);
        // Quoted first argument, doubled quote inside quotes, line ends inside quotes.
        queue_text("\"p q\"r \"a\"\"b", 1'b1);
        // Empty first argument, an escaped quote, a closed quote that goes on,
        // and trailing backslashes.
        queue_text("\t\\\\\\\"x\\\\\"y\"z \\\\", 1'b1);
        // A quote alone on the last byte.
        queue_text("a \"", 1'b1);
        drain();

        // Random lines in chunks; the third chunk runs without gaps or stalls.
        queued_chars = 0;
        for (int chunk = 0; chunk < 4; chunk++) begin
            pace   = (chunk != 2);
            target = queued_chars + 95;
            while (queued_chars < target) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 16);
                queue_random_line(len, $urandom_range(0, 9) == 0);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (split_q.size() != 0) begin
            errs++;
            $error("%0d expected result beats never arrived", split_q.size());
        end
        if (errs == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
